// ----- sv/bale_pkg.sv -----
// Shared types and constants for the bounded array list engine.
package bale_pkg;

    // Number of list slots, and the widths that follow from it.
    localparam int CAPACITY = 8;
    localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed widths of the item fields.
    localparam int OP_W         = 4;
    localparam int DATA_W       = 32;
    localparam int INDEX_W      = 3;
    localparam int STATUS_W     = 3;
    localparam int POS_FIELD_W  = 3;
    localparam int CNT_FIELD_W  = 4;

    // Operation codes; codes above OP_READ leave the list unchanged.
    typedef enum logic [OP_W-1:0] {
        OP_CLEAR      = 4'd0,
        OP_PUSH_FRONT = 4'd1,
        OP_PUSH_BACK  = 4'd2,
        OP_SORTED     = 4'd3,
        OP_POP_FRONT  = 4'd4,
        OP_POP_BACK   = 4'd5,
        OP_DELETE     = 4'd6,
        OP_SEARCH     = 4'd7,
        OP_READ       = 4'd8
    } op_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_RANGE    = 3'd4
    } status_t;

    // One input item.
    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic signed [DATA_W-1:0] value;
        logic [INDEX_W-1:0]       index;
    } req_t;

    // One result item.
    typedef struct packed {
        status_t                  status;
        logic [POS_FIELD_W-1:0]   position;
        logic signed [DATA_W-1:0] entry_value;
        logic [CNT_FIELD_W-1:0]   count;
    } rsp_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic                     open_slot;
        logic                     close_slot;
        logic [SLOT_W-1:0]        slot;
        logic signed [DATA_W-1:0] value;
        logic [CNT_W-1:0]         occupied;
    } cell_ctrl_t;

    // Compare flags returned by each cell.
    typedef struct packed {
        logic eq;
        logic gt;
    } cell_flags_t;

endpackage

// ----- sv/bale_cell.sv -----
// One list slot: holds an entry, compares it with the key and shifts with its neighbors.
module bale_cell
    import bale_pkg::*;
(
    input  logic                     clk,
    input  logic [SLOT_W-1:0]        cell_index,
    input  cell_ctrl_t               ctrl,
    input  logic signed [DATA_W-1:0] left_value,
    input  logic signed [DATA_W-1:0] right_value,
    output logic signed [DATA_W-1:0] entry_value,
    output cell_flags_t              flags
);

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;
    logic                     active;

    // A slot takes part in compares only while it lies below the count.
    assign active = (CNT_W'(cell_index) < ctrl.occupied);

    // Compare the held entry with the key of the current item.
    always_comb
    begin
        flags.eq = active && (entry_reg == ctrl.value);
        flags.gt = active && (entry_reg > ctrl.value);
    end

    // Opening a slot moves later entries up; closing one moves them down.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.open_slot)
        begin
            if (cell_index > ctrl.slot)
            begin
                entry_next = left_value;
            end
            else if (cell_index == ctrl.slot)
            begin
                entry_next = ctrl.value;
            end
        end
        else if (ctrl.close_slot)
        begin
            if (cell_index >= ctrl.slot)
            begin
                entry_next = right_value;
            end
        end
    end

    // The entry is payload and needs no reset.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry_value = entry_reg;

endmodule

// ----- sv/bounded_array_list_engine_unit.sv -----
// Top level of the bounded array list engine: control, count and the chain of cells.
//
// The block keeps an ordered list of up to CAPACITY signed 32-bit entries in a
// chain of cells, one entry per cell, and a count of the entries held.
// Request channel (req_valid, req_stall, req): each item carries an operation
// code, a value and an index. Result channel (rsp_valid, rsp_stall, rsp): each
// accepted item yields exactly one result with status, position, entry value
// and the count after the operation.
// The result is registered and presented in the cycle after the item is accepted. All
// cells compare against the key in parallel and shift together, so the block
// takes one item per cycle as long as the result side keeps up.
// The result sits in an output register. While that register is full and the
// receiver holds rsp_stall high, req_stall is raised and the list is frozen;
// a result held under stall does not change.
// Reset clears the count and the result valid flag. The entries themselves are
// not cleared; only slots below the count are ever read out.
module bounded_array_list_engine_unit
    import bale_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;
    rsp_t                     rsp_reg;
    rsp_t                     rsp_next;
    logic                     accept;
    cell_ctrl_t               ctrl;
    logic signed [DATA_W-1:0] cell_value [CAPACITY];
    cell_flags_t              cell_flags [CAPACITY];
    logic                     match_found;
    logic [SLOT_W-1:0]        match_slot;
    logic                     greater_found;
    logic [SLOT_W-1:0]        greater_slot;
    logic [SLOT_W-1:0]        take_slot;
    logic signed [DATA_W-1:0] take_value;
    logic                     is_full;
    logic                     is_empty;
    logic                     index_beyond;

    // The output register frees up when its result is taken.
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    assign is_full      = (count_reg == CNT_W'(CAPACITY));
    assign is_empty     = (count_reg == '0);
    assign index_beyond = ({{CNT_W{1'b0}}, req.index} >= {{INDEX_W{1'b0}}, count_reg});

    // Chain of cells; the end cells see the key and themselves as neighbors.
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [DATA_W-1:0] left_in;
            logic signed [DATA_W-1:0] right_in;
            if (gi == 0)
            begin : g_first
                assign left_in = ctrl.value;
            end
            else
            begin : g_mid_left
                assign left_in = cell_value[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_in = cell_value[gi];
            end
            else
            begin : g_mid_right
                assign right_in = cell_value[gi+1];
            end
            bale_cell u_cell (
                .clk         (clk),
                .cell_index  (SLOT_W'(gi)),
                .ctrl        (ctrl),
                .left_value  (left_in),
                .right_value (right_in),
                .entry_value (cell_value[gi]),
                .flags       (cell_flags[gi])
            );
        end
    endgenerate

    // First matching slot and first slot holding a greater entry.
    always_comb
    begin
        match_found   = 1'b0;
        match_slot    = '0;
        greater_found = 1'b0;
        greater_slot  = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (cell_flags[i].eq)
            begin
                match_found = 1'b1;
                match_slot  = SLOT_W'(i);
            end
            if (cell_flags[i].gt)
            begin
                greater_found = 1'b1;
                greater_slot  = SLOT_W'(i);
            end
        end
    end

    // Decode the operation into a cell command and a result.
    always_comb
    begin
        ctrl.open_slot  = 1'b0;
        ctrl.close_slot = 1'b0;
        ctrl.slot       = '0;
        ctrl.value      = req.value;
        ctrl.occupied   = count_reg;
        count_next      = count_reg;
        take_slot       = '0;
        rsp_next.status      = ST_OK;
        rsp_next.position    = '0;
        rsp_next.entry_value = '0;
        rsp_next.count       = '0;

        case (req.operation)
            OP_CLEAR:
            begin
                count_next = '0;
            end
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_SORTED:
            begin
                if (is_full)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    if (req.operation == OP_PUSH_FRONT)
                    begin
                        ctrl.slot = '0;
                    end
                    else if (req.operation == OP_PUSH_BACK || !greater_found)
                    begin
                        ctrl.slot = SLOT_W'(count_reg);
                    end
                    else
                    begin
                        ctrl.slot = greater_slot;
                    end
                    ctrl.open_slot    = 1'b1;
                    count_next        = count_reg + CNT_W'(1);
                    rsp_next.position = POS_FIELD_W'(ctrl.slot);
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (is_empty)
                begin
                    rsp_next.status = ST_EMPTY;
                end
                else
                begin
                    if (req.operation == OP_POP_FRONT)
                    begin
                        ctrl.slot = '0;
                    end
                    else
                    begin
                        ctrl.slot = SLOT_W'(count_reg - CNT_W'(1));
                    end
                    ctrl.close_slot      = 1'b1;
                    take_slot            = ctrl.slot;
                    count_next           = count_reg - CNT_W'(1);
                    rsp_next.position    = POS_FIELD_W'(ctrl.slot);
                    rsp_next.entry_value = take_value;
                end
            end
            OP_DELETE, OP_SEARCH:
            begin
                if (is_empty)
                begin
                    rsp_next.status = ST_EMPTY;
                end
                else if (!match_found)
                begin
                    rsp_next.status = ST_NOTFOUND;
                end
                else
                begin
                    ctrl.slot         = match_slot;
                    take_slot         = match_slot;
                    rsp_next.position = POS_FIELD_W'(match_slot);
                    if (req.operation == OP_DELETE)
                    begin
                        ctrl.close_slot      = 1'b1;
                        count_next           = count_reg - CNT_W'(1);
                        rsp_next.entry_value = take_value;
                    end
                end
            end
            OP_READ:
            begin
                if (index_beyond)
                begin
                    rsp_next.status = ST_RANGE;
                end
                else
                begin
                    take_slot            = SLOT_W'(req.index);
                    rsp_next.position    = POS_FIELD_W'(req.index);
                    rsp_next.entry_value = take_value;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase

        rsp_next.count = CNT_FIELD_W'(count_next);

        // Nothing moves in the chain unless the item is accepted.
        if (!accept)
        begin
            ctrl.open_slot  = 1'b0;
            ctrl.close_slot = 1'b0;
        end
    end

    // Single read port into the chain for removed or read entries.
    assign take_value = cell_value[take_slot];

    // Result valid flag follows acceptance and delivery.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The count never passes the number of cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("list count exceeds capacity");

    // An accepted item always leaves a result in the output register.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg)
        else $error("accepted item produced no result");

    // The reported count is the count now held.
    a_count_reported: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.count == CNT_FIELD_W'(count_reg)))
        else $error("reported count differs from held count");

    // An insert into a full list reports full and leaves the count alone.
    a_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_full && (req.operation == OP_PUSH_FRONT
            || req.operation == OP_PUSH_BACK || req.operation == OP_SORTED))
        |=> (rsp_reg.status == ST_FULL && count_reg == CNT_W'(CAPACITY)))
        else $error("insert into full list not rejected");

    // Removal from an empty list reports empty.
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_empty && (req.operation == OP_POP_FRONT
            || req.operation == OP_POP_BACK || req.operation == OP_DELETE))
        |=> (rsp_reg.status == ST_EMPTY && count_reg == '0))
        else $error("removal from empty list not rejected");

endmodule
